// ----- hw/rtl/rtq_pkg.sv -----
// ----------------------------------------------------------------------------
// rtq_pkg: shared types and constants of the ring task queue
// Request and result layouts, entry layout, codes and the cell control group.
// ----------------------------------------------------------------------------
`default_nettype none

package rtq_pkg;

  localparam int DEPTH        = 16;
  localparam int PAYLOAD_BITS = 64;
  localparam int CNT_W        = $clog2(DEPTH + 1);
  localparam int CAP_W        = 5;
  localparam int OWNER_W      = 32;

  localparam logic [CAP_W-1:0]   CAP_RESET = CAP_W'(16);
  localparam logic [OWNER_W-1:0] NO_OWNER  = '1;

  typedef enum logic [3:0] {
    ACT_APPEND   = 4'd0,
    ACT_INSERT   = 4'd1,
    ACT_START    = 4'd2,
    ACT_COMPLETE = 4'd3,
    ACT_FAIL     = 4'd4,
    ACT_CANCEL   = 4'd5,
    ACT_CLEAR    = 4'd6,
    ACT_REMOVE   = 4'd7,
    ACT_READ     = 4'd8
  } act_e;

  typedef enum logic [2:0] {
    ST_PENDING   = 3'd0,
    ST_RUNNING   = 3'd1,
    ST_DONE      = 3'd2,
    ST_FAILED    = 3'd3,
    ST_CANCELLED = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    ERR_NONE    = 3'd0,
    ERR_FULL    = 3'd1,
    ERR_EMPTY   = 3'd2,
    ERR_RANGE   = 3'd3,
    ERR_PENDING = 3'd4
  } err_e;

  typedef enum logic {
    REG_CAPACITY = 1'b0,
    REG_OWNER    = 1'b1
  } reg_e;

  typedef struct packed {
    logic [3:0]  action;
    logic [7:0]  task_type;
    logic [63:0] payload;
    logic [3:0]  position;
  } req_t;

  typedef struct packed {
    logic               ok;
    logic [2:0]         error_code;
    logic [3:0]         result_index;
    logic               notify;
    logic [7:0]         item_type;
    logic [2:0]         item_status;
    logic [63:0]        item_payload;
    logic signed [31:0] item_assignee;
    logic [4:0]         entries_now;
  } rsp_t;

  typedef struct packed {
    logic [7:0]              task_type;
    logic [PAYLOAD_BITS-1:0] payload;
    logic [2:0]              status;
    logic [OWNER_W-1:0]      assignee;
  } entry_t;

  typedef struct packed {
    logic load_new;
    logic take_prev;
    logic take_next;
    logic start_head;
  } cell_ctl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/rtq_cell.sv -----
// ----------------------------------------------------------------------------
// rtq_cell: one queue position
// Holds one task and takes a new task, its lower or upper neighbour's task,
// or a start stamp, as its control group says.
// ----------------------------------------------------------------------------
`default_nettype none

module rtq_cell (
  input  wire                          clk,
  input  wire rtq_pkg::cell_ctl_t      ctl,
  input  wire rtq_pkg::entry_t         new_entry,
  input  wire rtq_pkg::entry_t         prev_entry,
  input  wire rtq_pkg::entry_t         next_entry,
  input  wire [rtq_pkg::OWNER_W-1:0]   owner,
  output rtq_pkg::entry_t              entry
);

  always_ff @(posedge clk) begin
    if (ctl.load_new) begin
      entry <= new_entry;
    end else if (ctl.take_prev) begin
      entry <= prev_entry;
    end else if (ctl.take_next) begin
      entry <= next_entry;
    end else if (ctl.start_head) begin
      entry.status   <= rtq_pkg::ST_RUNNING;
      entry.assignee <= owner;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/ring_task_queue_with_head_status.sv -----
// ----------------------------------------------------------------------------
// ring_task_queue_with_head_status: task queue with a current-task head
// Top level: request decode, cell row control, result formation, registers.
// ----------------------------------------------------------------------------
// A request is accepted at a rising edge where start is high and busy is low;
// in the following cycle busy is high and the request is carried out across
// the whole row of cells at once; the result and done are registered from it.
// The result then sits on the result port for exactly one cycle with done
// high, and the receiver cannot stall it, so it must be taken there and then.
// busy is already low in that done cycle, so a fresh request may be issued
// alongside it; no request is accepted while busy is high. Tasks are kept in
// logical order: cell 0 is always the head, so insertion after the head and
// removal shift the row by one place in the execute cycle. Configuration writes
// (capacity and owner) should only be made while no request is outstanding.
// ----------------------------------------------------------------------------
`default_nettype none

module ring_task_queue_with_head_status (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           start,
  output logic                          busy,
  input  wire rtq_pkg::req_t            request,
  output logic                          done,
  output rtq_pkg::rsp_t                 result,
  input  wire                           cfg_we,
  input  wire                           cfg_index,
  input  wire [rtq_pkg::OWNER_W-1:0]    cfg_data
);

  localparam int DEPTH = rtq_pkg::DEPTH;
  localparam int CNT_W = rtq_pkg::CNT_W;

  // Control registers.
  logic [CNT_W-1:0]            count;
  logic [CNT_W-1:0]            count_next;
  logic [rtq_pkg::CAP_W-1:0]   capacity;
  logic [rtq_pkg::OWNER_W-1:0] owner;

  // The request being executed.
  rtq_pkg::req_t cmd;
  rtq_pkg::rsp_t rsp;

  rtq_pkg::entry_t    cell_q   [DEPTH];
  rtq_pkg::entry_t    prev_e   [DEPTH];
  rtq_pkg::entry_t    next_e   [DEPTH];
  rtq_pkg::cell_ctl_t cell_ctl [DEPTH];
  rtq_pkg::entry_t    new_entry;
  rtq_pkg::entry_t    sel_entry;

  logic [CNT_W-1:0] eff_cap;
  logic             full;
  logic             empty;
  logic             pos_valid;
  logic             accept;

  assign accept = start && !busy;

  // A capacity above the built depth is treated as the full depth.
  assign eff_cap   = (int'(capacity) > DEPTH) ? CNT_W'(DEPTH) : CNT_W'(capacity);
  assign full      = (count >= eff_cap);
  assign empty     = (count == '0);
  assign pos_valid = (int'(cmd.position) < int'(count));

  // A new task enters pending and unassigned.
  always_comb begin
    new_entry.task_type = cmd.task_type;
    new_entry.payload   = rtq_pkg::PAYLOAD_BITS'(cmd.payload);
    new_entry.status    = rtq_pkg::ST_PENDING;
    new_entry.assignee  = rtq_pkg::NO_OWNER;
  end

  // The entry at the requested position, for reads.
  always_comb begin
    sel_entry = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (int'(cmd.position) == i) begin
        sel_entry = sel_entry | cell_q[i];
      end
    end
  end

  // Per-cell control. Appending loads the cell just past the tail; inserting
  // loads cell 1 (cell 0 if empty) and pushes the rest up; finishing the head
  // or removing an entry pulls everything from the chosen place down by one.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      cell_ctl[i] = '0;
      if (busy) begin
        case (cmd.action)
          rtq_pkg::ACT_APPEND, rtq_pkg::ACT_INSERT: begin
            if (!full) begin
              if (cmd.action == rtq_pkg::ACT_APPEND || empty) begin
                cell_ctl[i].load_new = (i == int'(count));
              end else begin
                cell_ctl[i].load_new  = (i == 1);
                cell_ctl[i].take_prev = (i >= 2) && (i <= int'(count));
              end
            end
          end
          rtq_pkg::ACT_START: begin
            cell_ctl[i].start_head = (i == 0) && !empty &&
                                     (cell_q[0].status == rtq_pkg::ST_PENDING);
          end
          rtq_pkg::ACT_COMPLETE, rtq_pkg::ACT_FAIL, rtq_pkg::ACT_CANCEL: begin
            cell_ctl[i].take_next = !empty;
          end
          rtq_pkg::ACT_REMOVE: begin
            cell_ctl[i].take_next = pos_valid && (i >= int'(cmd.position));
          end
          default: begin
            cell_ctl[i] = '0;
          end
        endcase
      end
    end
  end

  // Result formation. A finished head is reported with its new status.
  always_comb begin
    logic            report;
    logic [2:0]      rep_status;
    rtq_pkg::entry_t rep_entry;

    rsp        = '0;
    count_next = count;
    report     = 1'b0;
    rep_status = cell_q[0].status;
    rep_entry  = cell_q[0];

    case (cmd.action)
      rtq_pkg::ACT_APPEND, rtq_pkg::ACT_INSERT: begin
        if (full) begin
          rsp.error_code = rtq_pkg::ERR_FULL;
        end else begin
          rsp.ok = 1'b1;
          if (cmd.action == rtq_pkg::ACT_APPEND) begin
            rsp.result_index = 4'(count);
          end else begin
            rsp.result_index = empty ? 4'd0 : 4'd1;
          end
          count_next = count + CNT_W'(1);
        end
      end
      rtq_pkg::ACT_START: begin
        if (empty) begin
          rsp.error_code = rtq_pkg::ERR_EMPTY;
        end else if (cell_q[0].status != rtq_pkg::ST_PENDING) begin
          rsp.error_code = rtq_pkg::ERR_PENDING;
        end else begin
          rsp.ok = 1'b1;
        end
      end
      rtq_pkg::ACT_COMPLETE, rtq_pkg::ACT_FAIL, rtq_pkg::ACT_CANCEL: begin
        if (empty) begin
          rsp.error_code = rtq_pkg::ERR_EMPTY;
        end else begin
          rsp.ok     = 1'b1;
          report     = 1'b1;
          count_next = count - CNT_W'(1);
          if (cmd.action == rtq_pkg::ACT_COMPLETE) begin
            rep_status = rtq_pkg::ST_DONE;
          end else if (cmd.action == rtq_pkg::ACT_FAIL) begin
            rep_status = rtq_pkg::ST_FAILED;
          end else begin
            rep_status = rtq_pkg::ST_CANCELLED;
          end
        end
      end
      rtq_pkg::ACT_CLEAR: begin
        rsp.ok     = 1'b1;
        count_next = '0;
        if (!empty && cell_q[0].status == rtq_pkg::ST_RUNNING) begin
          report     = 1'b1;
          rep_status = rtq_pkg::ST_CANCELLED;
        end
      end
      rtq_pkg::ACT_REMOVE: begin
        if (!pos_valid) begin
          rsp.error_code = rtq_pkg::ERR_RANGE;
        end else begin
          rsp.ok     = 1'b1;
          count_next = count - CNT_W'(1);
          if (cmd.position == '0) begin
            report     = 1'b1;
            rep_status = rtq_pkg::ST_CANCELLED;
          end
        end
      end
      rtq_pkg::ACT_READ: begin
        if (!pos_valid) begin
          rsp.error_code = rtq_pkg::ERR_RANGE;
        end else begin
          rsp.ok     = 1'b1;
          report     = 1'b1;
          rep_entry  = sel_entry;
          rep_status = sel_entry.status;
        end
      end
      default: begin
        rsp = '0;
      end
    endcase

    if (report) begin
      rsp.item_type     = rep_entry.task_type;
      rsp.item_status   = rep_status;
      rsp.item_payload  = 64'(rep_entry.payload);
      rsp.item_assignee = rep_entry.assignee;
    end
    rsp.notify      = report && (cmd.action != rtq_pkg::ACT_READ);
    rsp.entries_now = 5'(count_next);
  end

  // The row of cells. The head's lower neighbour is never selected; the top
  // cell takes the new entry in place of an upper neighbour when the row shifts.
  genvar g;
  for (g = 0; g < DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign prev_e[g] = new_entry;
    end else begin : g_prev
      assign prev_e[g] = cell_q[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign next_e[g] = new_entry;
    end else begin : g_next
      assign next_e[g] = cell_q[g+1];
    end

    rtq_cell u_cell (
      .clk        (clk),
      .ctl        (cell_ctl[g]),
      .new_entry  (new_entry),
      .prev_entry (prev_e[g]),
      .next_entry (next_e[g]),
      .owner      (owner),
      .entry      (cell_q[g])
    );
  end

  // Control state and configuration.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      done     <= 1'b0;
      count    <= '0;
      capacity <= rtq_pkg::CAP_RESET;
      owner    <= rtq_pkg::NO_OWNER;
    end else begin
      busy <= accept;
      done <= busy;
      if (busy) begin
        count <= count_next;
      end
      if (cfg_we) begin
        case (cfg_index)
          rtq_pkg::REG_CAPACITY: capacity <= cfg_data[rtq_pkg::CAP_W-1:0];
          rtq_pkg::REG_OWNER:    owner    <= cfg_data;
          default:               owner    <= owner;
        endcase
      end
    end
  end

  // Request and result payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd <= request;
    end
    if (busy) begin
      result <= rsp;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/rtq_checker.sv -----
// ----------------------------------------------------------------------------
// rtq_checker: port-level checks for the ring task queue
// Watches the request and result ports and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rtq_checker (
  input wire                clk,
  input wire                rst,
  input wire                start,
  input wire                busy,
  input wire                done,
  input wire rtq_pkg::rsp_t result
);

  // An accepted request is executed in the very next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  // Every execute cycle is followed by exactly one result.
  a_busy_done: assert property (@(posedge clk) disable iff (rst)
    busy |=> done)
    else $error("execute cycle gave no result");

  // Results never come on consecutive cycles.
  a_done_gap: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("results on consecutive cycles");

  // A refused request never reports a finished task.
  a_no_notify_on_error: assert property (@(posedge clk) disable iff (rst)
    (done && !result.ok) |-> !result.notify)
    else $error("notification on a refused request");

  // The task count never exceeds the built depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> (int'(result.entries_now) <= rtq_pkg::DEPTH))
    else $error("task count above depth");

endmodule

bind ring_task_queue_with_head_status rtq_checker u_rtq_checker (.*);

`default_nettype wire
